[rtl/vas_pkg.sv]
// Shared types, constants and helpers for the voice allocator.
// Used by vas_engine, the top level and the bench; no dependencies of its own.
package vas_pkg;

  localparam int NUM_VOICES = 4;
  localparam int IDX_W      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CNT_W      = $clog2(NUM_VOICES + 1);
  localparam int AGE_W      = 32;
  localparam int ENT_W      = AGE_W + 1;  // {in_use, age}
  localparam int SLOT_W     = 2;
  localparam int VST_W      = 3;
  localparam int VC_W       = 3;

  localparam logic REG_VOICE_COUNT = 1'b0;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_REPORT = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_WRITE,
    ST_DONE
  } fsm_e;

  typedef struct packed {
    logic             clear;
    logic [CNT_W-1:0] count;
  } pool_cfg_t;

  typedef struct packed {
    logic [SLOT_W-1:0] granted;
    logic              grant_valid;
    logic              stole;
    logic              any_playing;
  } res_t;

  localparam logic [VST_W-1:0] VS_FREE    = 3'd0;
  localparam logic [VST_W-1:0] VS_STOPPED = 3'd7;

  function automatic logic is_idle(input logic [VST_W-1:0] st);
    return (st == VS_FREE) || (st == VS_STOPPED);
  endfunction

endpackage

[rtl/vas_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vas_ram #(
  parameter int Width = 8,
  parameter int Depth = 4,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/vas_engine.sv]
// Sequencer for the voice allocator: scans the slot RAM for ticks and steals,
// does read-modify-write of {in_use, age}, keeps per-slot playing flags.
// Depends on vas_pkg and vas_ram.
module vas_engine (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  vas_pkg::pool_cfg_t       cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  vas_pkg::op_e             in_op_i,
  input  logic [vas_pkg::SLOT_W-1:0] in_slot_i,
  input  logic [vas_pkg::VST_W-1:0]  in_state_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output vas_pkg::res_t            res_o
);

  localparam int NV    = vas_pkg::NUM_VOICES;
  localparam int IDX_W = vas_pkg::IDX_W;
  localparam int CNT_W = vas_pkg::CNT_W;
  localparam int AGE_W = vas_pkg::AGE_W;
  localparam int ENT_W = vas_pkg::ENT_W;

  vas_pkg::fsm_e     state_q, state_d;
  vas_pkg::op_e      op_q, op_d;
  logic [CNT_W-1:0]  rd_cnt_q, rd_cnt_d;
  logic              rdv_q, rdv_d;
  logic [IDX_W-1:0]  rd_addr_q, rd_addr_d;
  logic [IDX_W-1:0]  best_q, best_d;
  logic [AGE_W-1:0]  best_age_q, best_age_d;
  logic              steal_q, steal_d;
  logic [NV-1:0]     play_q, play_d;
  logic [NV-1:0]     ent_val_q, ent_val_d;

  logic [CNT_W-1:0]  n;
  logic [NV-1:0]     pool_mask;
  logic [NV-1:0]     idle_vec;
  logic              any_idle;
  logic [IDX_W-1:0]  first_idle;
  logic              rd_issue;
  logic              scan_last;
  logic [IDX_W-1:0]  data_addr;
  logic [ENT_W-1:0]  eff;
  logic              eff_inuse;
  logic [AGE_W-1:0]  eff_age;
  logic [AGE_W-1:0]  age_inc;
  logic [ENT_W-1:0]  tick_wdata;
  logic [31:0]       best_ext;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;

  assign n = cfg_i.count;

  always_comb begin
    for (int i = 0; i < NV; i++) begin
      pool_mask[i] = (n > CNT_W'(i));
    end
  end

  assign idle_vec = ~play_q & pool_mask;
  assign any_idle = |idle_vec;

  // lowest idle slot wins
  always_comb begin
    first_idle = '0;
    for (int i = NV - 1; i >= 0; i--) begin
      if (idle_vec[i]) begin
        first_idle = IDX_W'(i);
      end
    end
  end

  assign rd_issue  = (state_q == vas_pkg::ST_SCAN) && (rd_cnt_q < n);
  assign scan_last = rdv_q && (rd_addr_q == IDX_W'(n - CNT_W'(1)));

  // entries never written since the pool was prepared read as zero
  assign data_addr  = (state_q == vas_pkg::ST_WRITE) ? best_q : rd_addr_q;
  assign eff        = ent_val_q[data_addr] ? ram_rdata : '0;
  assign eff_inuse  = eff[AGE_W];
  assign eff_age    = eff[AGE_W-1:0];
  assign age_inc    = eff_age + AGE_W'(1);
  assign tick_wdata = (!play_q[rd_addr_q] && eff_inuse) ? '0 : {eff_inuse, age_inc};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vas_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_op_i)
            vas_pkg::OP_TICK:   state_d = vas_pkg::ST_SCAN;
            vas_pkg::OP_ALLOC:  state_d = any_idle ? vas_pkg::ST_FETCH : vas_pkg::ST_SCAN;
            vas_pkg::OP_REPORT: state_d = vas_pkg::ST_DONE;
            vas_pkg::OP_NONE:   state_d = vas_pkg::ST_DONE;
          endcase
        end
      end
      vas_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_d = (op_q == vas_pkg::OP_TICK) ? vas_pkg::ST_DONE : vas_pkg::ST_WRITE;
        end
      end
      vas_pkg::ST_FETCH: state_d = vas_pkg::ST_WRITE;
      vas_pkg::ST_WRITE: state_d = vas_pkg::ST_DONE;
      vas_pkg::ST_DONE: begin
        if (res_ready_i) begin
          state_d = vas_pkg::ST_IDLE;
        end
      end
      default: state_d = vas_pkg::ST_IDLE;
    endcase
  end

  // outputs: handshake and RAM controls
  always_comb begin
    in_ready_o  = (state_q == vas_pkg::ST_IDLE);
    res_valid_o = (state_q == vas_pkg::ST_DONE);
    ram_re      = rd_issue || (state_q == vas_pkg::ST_FETCH);
    ram_raddr   = (state_q == vas_pkg::ST_FETCH) ? best_q : rd_cnt_q[IDX_W-1:0];
    ram_we      = 1'b0;
    ram_waddr   = rd_addr_q;
    ram_wdata   = tick_wdata;
    unique case (state_q)
      vas_pkg::ST_SCAN: begin
        ram_we = rdv_q && (op_q == vas_pkg::OP_TICK);
      end
      vas_pkg::ST_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = best_q;
        ram_wdata = {1'b1, steal_q ? '0 : eff_age};
      end
      default: ram_we = 1'b0;
    endcase
  end

  // datapath next values
  always_comb begin
    op_d       = op_q;
    rd_cnt_d   = rd_cnt_q;
    rdv_d      = 1'b0;
    rd_addr_d  = rd_addr_q;
    best_d     = best_q;
    best_age_d = best_age_q;
    steal_d    = steal_q;
    play_d     = play_q;
    ent_val_d  = ent_val_q;
    unique case (state_q)
      vas_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          op_d       = in_op_i;
          rd_cnt_d   = '0;
          steal_d    = (in_op_i == vas_pkg::OP_ALLOC) && !any_idle;
          best_d     = any_idle ? first_idle : '0;
          best_age_d = '0;
          if ((in_op_i == vas_pkg::OP_REPORT) && (32'(in_slot_i) < 32'(n))) begin
            play_d[IDX_W'(in_slot_i)] = !vas_pkg::is_idle(in_state_i);
          end
        end
      end
      vas_pkg::ST_SCAN: begin
        rdv_d = rd_issue;
        if (rd_issue) begin
          rd_addr_d = rd_cnt_q[IDX_W-1:0];
          rd_cnt_d  = rd_cnt_q + CNT_W'(1);
        end
        if (rdv_q) begin
          if (op_q == vas_pkg::OP_TICK) begin
            ent_val_d[rd_addr_q] = 1'b1;
          end else if (eff_age >= best_age_q) begin
            // ">=" lets the later slot win a tie
            best_d     = rd_addr_q;
            best_age_d = eff_age;
          end
        end
      end
      vas_pkg::ST_WRITE: begin
        ent_val_d[best_q] = 1'b1;
        if (steal_q) begin
          play_d[best_q] = 1'b0;
        end
      end
      default: rdv_d = 1'b0;
    endcase
    if (cfg_i.clear) begin
      play_d    = '0;
      ent_val_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= vas_pkg::ST_IDLE;
      op_q      <= vas_pkg::OP_NONE;
      rd_cnt_q  <= '0;
      rdv_q     <= 1'b0;
      best_q    <= '0;
      steal_q   <= 1'b0;
      play_q    <= '0;
      ent_val_q <= '0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      rd_cnt_q  <= rd_cnt_d;
      rdv_q     <= rdv_d;
      best_q    <= best_d;
      steal_q   <= steal_d;
      play_q    <= play_d;
      ent_val_q <= ent_val_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q  <= rd_addr_d;
    best_age_q <= best_age_d;
  end

  vas_ram #(
    .Width(ENT_W),
    .Depth(NV)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign best_ext          = 32'(best_q);
  assign res_o.grant_valid = (op_q == vas_pkg::OP_ALLOC);
  assign res_o.granted     = (op_q == vas_pkg::OP_ALLOC) ? best_ext[1:0] : '0;
  assign res_o.stole       = (op_q == vas_pkg::OP_ALLOC) && steal_q;
  assign res_o.any_playing = |(play_q & pool_mask);

endmodule

[rtl/voice_allocator_oldest_steal.sv]
// Top level of the voice allocator: APB register, stream ports, result register.
// Depends on vas_pkg and vas_engine.
//
//  channel  | direction | handshake               | payload
//  s_axis   | in        | s_axis_tvalid/tready    | tuser: operation; tdata: slot, state
//  m_axis   | out       | m_axis_tvalid/tready    | tuser: grant_valid; tdata: grant info
//  apb      | in        | psel/penable (pready=1) | voice_count at address 0
//
// The engine takes one item at a time; a tick or a steal reads the RAM once
// per slot of the pool during the scan.
// Reset and a voice_count write clear the pool at once (per-entry valid bits).
// A result waits in the output register; the next beat is accepted meanwhile
// and held in the engine only if the output register is still full.
module voice_allocator_oldest_steal (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [1:0] slot_index, [4:2] voice_state, rest zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] operation
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [1:0] granted_slot, [2] stole_voice,
                                        // [3] any_playing, rest zero
  output logic        m_axis_tuser_o    // [0] grant_valid
);

  localparam int CNT_W = vas_pkg::CNT_W;

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               cfg_we;
  logic [2:0]         wr_cnt;
  vas_pkg::pool_cfg_t pool_cfg;

  logic               res_valid, res_ready;
  vas_pkg::res_t      res;
  logic               out_valid_q;
  vas_pkg::res_t      out_res_q;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == vas_pkg::REG_VOICE_COUNT);
  assign wr_cnt = pwdata[vas_pkg::VC_W-1:0];

  // saturate the pool size into 1..NUM_VOICES
  always_comb begin
    cnt_d = cnt_q;
    if (cfg_we) begin
      if (wr_cnt == '0) begin
        cnt_d = CNT_W'(1);
      end else if (32'(wr_cnt) > vas_pkg::NUM_VOICES) begin
        cnt_d = CNT_W'(vas_pkg::NUM_VOICES);
      end else begin
        cnt_d = CNT_W'(wr_cnt);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CNT_W'(vas_pkg::NUM_VOICES);
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign prdata = (paddr[2] == vas_pkg::REG_VOICE_COUNT) ? 32'(cnt_q) : '0;

  assign pool_cfg.clear = cfg_we;
  assign pool_cfg.count = cnt_q;

  vas_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (pool_cfg),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_op_i    (vas_pkg::op_e'(s_axis_tuser_i)),
    .in_slot_i  (s_axis_tdata_i[1:0]),
    .in_state_i (s_axis_tdata_i[4:2]),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_res_q.any_playing, out_res_q.stole, out_res_q.granted};
  assign m_axis_tuser_o  = out_res_q.grant_valid;

  // an accepted beat leaves the engine busy in the cycle after it
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted twice in a row");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (32'(cnt_q) <= vas_pkg::NUM_VOICES))
    else $error("pool size out of range");

  a_no_grant_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> (m_axis_tdata_o[2:0] == 3'b000))
    else $error("grant fields set without a grant");

  a_single_slot_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o && (cnt_q == CNT_W'(1)) |->
      (m_axis_tdata_o[1:0] == 2'b00))
    else $error("grant beyond a one-slot pool");

endmodule

[tb/voice_allocator_oldest_steal_test.sv]
// Self-checking bench for voice_allocator_oldest_steal: stream stimulus, APB writes,
// and a slot-pool predictor in a small scoreboard class.
// Depends on vas_pkg and the RTL of the block.
module voice_allocator_oldest_steal_test;
  import vas_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD   = 400;
  localparam int IDLE_PAUSE  = 20;

  // Predicts one result beat per input beat from its own copy of the pool.
  class alloc_scoreboard;
    logic [VST_W-1:0] play_st [NUM_VOICES];
    logic [AGE_W-1:0] age     [NUM_VOICES];
    bit               in_use  [NUM_VOICES];
    int               pool_size;
    res_t             grant_q [$];
    int               errors;

    function new();
      clear_pool();
      pool_size = NUM_VOICES;
      errors = 0;
    endfunction

    function void clear_pool();
      for (int i = 0; i < NUM_VOICES; i++) begin
        play_st[i] = VS_FREE;
        age[i]     = '0;
        in_use[i]  = 1'b0;
      end
    endfunction

    function bit resting(logic [VST_W-1:0] st);
      return st == VS_FREE || st == VS_STOPPED;
    endfunction

    function void set_voice_count(logic [31:0] wdata);
      logic [2:0] v;
      v = wdata[2:0];
      if (v == 0) pool_size = 1;
      else if (v > NUM_VOICES) pool_size = NUM_VOICES;
      else pool_size = int'(v);
      clear_pool();
    endfunction

    function int pending();
      return grant_q.size();
    endfunction

    function void note_beat(op_e op, logic [1:0] idx, logic [VST_W-1:0] st);
      res_t             r;
      int               best;
      bit               found;
      logic [AGE_W-1:0] best_age;
      r = '0;
      case (op)
        OP_TICK: begin
          for (int i = 0; i < pool_size; i++) begin
            age[i] = age[i] + 1;
            if (resting(play_st[i]) && in_use[i]) begin
              age[i]    = '0;
              in_use[i] = 1'b0;
            end
          end
        end
        OP_ALLOC: begin
          found    = 1'b0;
          best     = 0;
          best_age = '0;
          for (int i = 0; i < pool_size && !found; i++) begin
            if (resting(play_st[i])) begin
              best  = i;
              found = 1'b1;
            end else if (age[i] >= best_age) begin
              // ties go to the later slot
              best     = i;
              best_age = age[i];
            end
          end
          if (!found) begin
            play_st[best] = VS_FREE;
            age[best]     = '0;
          end
          in_use[best]  = 1'b1;
          r.granted     = best[SLOT_W-1:0];
          r.grant_valid = 1'b1;
          r.stole       = !found;
        end
        OP_REPORT: begin
          if (idx < pool_size) play_st[idx] = st;
        end
        default: ;
      endcase
      for (int i = 0; i < pool_size; i++)
        if (!resting(play_st[i])) r.any_playing = 1'b1;
      grant_q.push_back(r);
    endfunction

    function void check_beat(logic [7:0] tdata, logic tuser);
      res_t exp_r;
      if (grant_q.size() == 0) begin
        $error("unexpected result beat: tdata %h tuser %b", tdata, tuser);
        errors++;
        return;
      end
      exp_r = grant_q.pop_front();
      if (tdata[1:0] !== exp_r.granted) begin
        $error("granted_slot expected %0d got %0d", exp_r.granted, tdata[1:0]);
        errors++;
      end
      if (tuser !== exp_r.grant_valid) begin
        $error("grant_valid expected %0d got %0d", exp_r.grant_valid, tuser);
        errors++;
      end
      if (tdata[2] !== exp_r.stole) begin
        $error("stole_voice expected %0d got %0d", exp_r.stole, tdata[2]);
        errors++;
      end
      if (tdata[3] !== exp_r.any_playing) begin
        $error("any_playing expected %0d got %0d", exp_r.any_playing, tdata[3]);
        errors++;
      end
      if (tdata[7:4] !== 4'b0) begin
        $error("tdata padding expected 0 got %h", tdata[7:4]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        s_valid, s_ready;
  logic [7:0]  s_data;   // [1:0] slot_index, [4:2] voice_state, rest zero
  logic [1:0]  s_user;   // [1:0] operation
  logic        m_valid, m_ready;
  logic [7:0]  m_data;   // [1:0] granted_slot, [2] stole_voice, [3] any_playing
  logic        m_user;   // [0] grant_valid

  alloc_scoreboard sb = new();
  int unsigned     cycle_cnt;
  bit              hold_request;
  bit              fast_mode;

  voice_allocator_oldest_steal i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) sb.check_beat(m_data, m_user);
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // result side: random ready, a long hold on request, always ready in fast mode
  initial begin
    int on_len;
    int off_len;
    m_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (LONG_HOLD) begin
          @(negedge clk_i);
          m_ready <= 1'b0;
        end
      end else if (fast_mode) begin
        @(negedge clk_i);
        m_ready <= 1'b1;
      end else begin
        on_len  = $urandom_range(1, 16);
        off_len = idle_len();
        repeat (on_len) begin
          @(negedge clk_i);
          m_ready <= 1'b1;
        end
        repeat (off_len) begin
          @(negedge clk_i);
          m_ready <= 1'b0;
        end
      end
    end
  end

  task automatic send_beat(op_e op, logic [1:0] idx, logic [VST_W-1:0] st);
    int gap;
    gap = fast_mode ? 0 : idle_len();
    repeat (gap) begin
      @(negedge clk_i);
      s_valid <= 1'b0;
    end
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {3'b000, st, idx};
    do @(posedge clk_i); while (!s_ready);
    sb.note_beat(op, idx, st);
  endtask

  // lets every result out, then pauses so the engine is surely idle
  task automatic drain();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (IDLE_PAUSE) @(posedge clk_i);
  endtask

  task automatic write_voice_count(logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_VOICE_COUNT, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_voice_count(value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_beat();
    int               r;
    logic [1:0]       idx;
    logic [VST_W-1:0] st;
    logic [1:0]       any_idx;
    logic [VST_W-1:0] any_st;
    r       = $urandom_range(0, 99);
    any_idx = 2'($urandom_range(0, 3));
    any_st  = VST_W'($urandom_range(0, 7));
    if ($urandom_range(0, 5) == 0) idx = 2'($urandom_range(0, 3));
    else idx = 2'($urandom_range(0, sb.pool_size - 1));
    // active states dominate so the pool saturates and steals occur
    if ($urandom_range(0, 2) == 0) st = $urandom_range(0, 1) ? VS_STOPPED : VS_FREE;
    else st = VST_W'($urandom_range(1, 6));
    if (r < 30) send_beat(OP_TICK, any_idx, any_st);
    else if (r < 55) send_beat(OP_ALLOC, any_idx, any_st);
    else if (r < 95) send_beat(OP_REPORT, idx, st);
    else send_beat(OP_NONE, any_idx, any_st);
  endtask

  initial begin
    int n_phase;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    s_valid      = 1'b0;
    s_data       = '0;
    s_user       = OP_TICK;
    hold_request = 1'b0;
    fast_mode    = 1'b0;
    cycle_cnt    = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset pool of four: unused op, empty tick, grants, full pool steals
    send_beat(OP_NONE, 2'd3, 3'd7);
    send_beat(OP_TICK, 2'd0, 3'd0);
    send_beat(OP_ALLOC, 2'd0, 3'd0);
    send_beat(OP_REPORT, 2'd0, 3'd3);
    send_beat(OP_ALLOC, 2'd0, 3'd0);
    send_beat(OP_REPORT, 2'd1, 3'd5);
    send_beat(OP_REPORT, 2'd2, 3'd1);
    send_beat(OP_REPORT, 2'd3, 3'd6);
    send_beat(OP_ALLOC, 2'd0, 3'd0);    // equal ages: last slot is stolen
    send_beat(OP_TICK, 2'd0, 3'd0);     // stolen slot retires
    send_beat(OP_REPORT, 2'd3, 3'd2);
    send_beat(OP_TICK, 2'd0, 3'd0);
    send_beat(OP_ALLOC, 2'd0, 3'd0);    // oldest among several ties
    send_beat(OP_REPORT, 2'd0, 3'd7);   // stopped counts as idle
    send_beat(OP_TICK, 2'd0, 3'd0);
    send_beat(OP_ALLOC, 2'd0, 3'd0);
    send_beat(OP_REPORT, 2'd1, 3'd4);
    drain();

    // single slot: out-of-pool reports are dropped
    write_voice_count(32'd1);
    send_beat(OP_REPORT, 2'd1, 3'd4);
    send_beat(OP_REPORT, 2'd0, 3'd4);
    send_beat(OP_ALLOC, 2'd0, 3'd0);
    send_beat(OP_TICK, 2'd0, 3'd0);
    send_beat(OP_REPORT, 2'd3, 3'd7);
    drain();
    write_voice_count(32'd0);           // saturates to one slot
    send_beat(OP_REPORT, 2'd0, 3'd2);
    send_beat(OP_ALLOC, 2'd0, 3'd0);
    drain();
    write_voice_count(32'd7);           // saturates to the full pool
    send_beat(OP_ALLOC, 2'd2, 3'd5);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_voice_count(ph == 0 ? 32'd4 : {$urandom} & 32'hFFFF_FFFF);
      if (ph == 1) hold_request = 1'b1;
      fast_mode = (ph == 2);
      n_phase = 80;
      repeat (n_phase) random_beat();
      drain();
    end
    fast_mode = 1'b0;
    repeat (IDLE_PAUSE) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[voice_allocator_oldest_steal.f]
rtl/vas_pkg.sv
rtl/vas_ram.sv
rtl/vas_engine.sv
rtl/voice_allocator_oldest_steal.sv
tb/voice_allocator_oldest_steal_test.sv
